// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== hw/rtl/kcq_pkg.sv =====
// ----------------------------------------------------------------------------
// kcq_pkg
// Shared types and constants of the k-clique search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kcq_pkg;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_CLIQUE_DEF = 16;
	localparam int CFG_W = 7;
	localparam int KW = 5;
	localparam int VW = 7;
	localparam logic [VW-1:0] DEG_CAP = 7'd127;
	localparam logic CFG_CLIQUE_SIZE = 1'b0;
	localparam logic CFG_VERTEX_COUNT = 1'b1;
	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE1,
		ST_EDGE2,
		ST_CHECK,
		ST_WAITRD,
		ST_BACK,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/k_clique_existence_search_top.sv =====
// Usage of k_clique_existence_search_top.
// Input channel (in_valid/in_ready) takes one word: kind, vertex_a, vertex_b.
// An edge word (kind 0) sets both adjacency bits and raises both degrees;
// it yields no output. A search word (kind 1) yields one output word with
// found on out_valid/out_ready.
// A two-entry queue decouples word intake from the engine.
// An edge holds the engine while it reads the old rows and degrees and then
// writes the new ones, one endpoint after the other.
// A search raises out_valid once the engine has tested candidate vertices,
// descended levels and stepped back through the backtracking tree; this
// loop over the single adjacency row read port sets the time. The engine
// takes no new word until the result word has been accepted.
// Config registers: index 0 clique_size, index 1 vertex_count; the user
// writes cfg_we/cfg_index/cfg_data only while the block is idle (unchecked).
// Reset clears the graph and the degrees at once through per-vertex valid
// bits, with no clearing pass, and restores clique_size 3 and vertex_count 64.
// While out_ready is low a finished result holds and the engine waits;
// the queue still takes up to two further words.
// ----------------------------------------------------------------------------
// k_clique_existence_search_top
// Top level of the k-clique existence search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module k_clique_existence_search_top #(
	parameter int MAX_VERTICES = kcq_pkg::MAX_VERTICES_DEF,
	parameter int MAX_CLIQUE = kcq_pkg::MAX_CLIQUE_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    kind,
	input  wire logic [kcq_pkg::VW-1:0]  vertex_a,
	input  wire logic [kcq_pkg::VW-1:0]  vertex_b,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         found,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_index,
	input  wire logic [kcq_pkg::CFG_W-1:0] cfg_data
);
	logic [kcq_pkg::KW-1:0] k_q;
	logic [kcq_pkg::VW-1:0] n_q;
	kcq_pkg::cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;

	assign in_cmd = '{kind: kind, a: vertex_a, b: vertex_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= kcq_pkg::KW'(3);
			n_q <= kcq_pkg::VW'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				kcq_pkg::CFG_CLIQUE_SIZE: k_q <= cfg_data[kcq_pkg::KW-1:0];
				kcq_pkg::CFG_VERTEX_COUNT: n_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	kcq_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	kcq_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_CLIQUE(MAX_CLIQUE)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.k_cfg(k_q), .n_cfg(n_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_found(found)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/kcq_front.sv =====
// ----------------------------------------------------------------------------
// kcq_front
// Accepts input words and queues them as commands for the search engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kcq_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire kcq_pkg::cmd_t in_cmd,
	output logic               q_valid,
	input  wire logic          q_ready,
	output kcq_pkg::cmd_t      q_cmd
);
	kcq_pkg::cmd_t mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`ASSERT_IMPLIES(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'd2)
	`ASSERT_NEXT(a_full_no_push, clk, arst_n, cnt_q == 2'd2 && !pop, cnt_q == 2'd2)
	`ASSERT_IMPLIES(a_empty_ptr, clk, arst_n, cnt_q == 2'd0, wp_q == rp_q)
endmodule
`default_nettype wire

// ===== hw/rtl/kcq_engine.sv =====
// ----------------------------------------------------------------------------
// kcq_engine
// Executes edge inserts and runs the backtracking clique search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kcq_engine #(
	parameter int MAX_VERTICES = kcq_pkg::MAX_VERTICES_DEF,
	parameter int MAX_CLIQUE = kcq_pkg::MAX_CLIQUE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	output logic                     q_ready,
	input  wire kcq_pkg::cmd_t       q_cmd,
	input  wire logic [kcq_pkg::KW-1:0] k_cfg,
	input  wire logic [kcq_pkg::VW-1:0] n_cfg,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     out_found
);
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int VXW = $clog2(MAX_VERTICES + 2);
	localparam int LW = $clog2(MAX_CLIQUE + 2);
	localparam int SW = $clog2(MAX_CLIQUE);

	logic [MAX_VERTICES-1:0] adj_valid_q;
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [kcq_pkg::VW-1:0]  deg_mem [MAX_VERTICES];
	logic [AW-1:0]           stack_q [MAX_CLIQUE];
	logic [MAX_VERTICES-1:0] cand_q [MAX_CLIQUE];
	logic [MAX_VERTICES-1:0] row_rd_q;
	logic                    row_vld_q;
	logic [kcq_pkg::VW-1:0]  deg_rd_q;
	logic                    deg_vld_q;

	kcq_pkg::state_t state_q, state_d;
	logic [VXW-1:0] v_q, v_d;
	logic [LW-1:0]  lvl_q;
	logic [VXW-1:0] kx_q, nx_q;
	logic [AW-1:0]  ea_q, eb_q;
	logic           ok_q;
	logic           res_q, resv_q;

	logic [kcq_pkg::VW-1:0] n_eff;
	logic edge_ok, take, self_loop;
	logic [AW-1:0] ca, cb, vi, deg_addr;
	logic [MAX_VERTICES-1:0] cand_cur, row_eff;
	logic [kcq_pkg::VW-1:0] deg_eff, deg_inc1, deg_inc2;
	logic v_in_range, v_pass;
	logic [SW-1:0] li;

	assign n_eff = (int'(n_cfg) > MAX_VERTICES) ? kcq_pkg::VW'(MAX_VERTICES) : n_cfg;
	assign edge_ok = q_cmd.a != '0 && int'(q_cmd.a) <= MAX_VERTICES
		&& q_cmd.b != '0 && int'(q_cmd.b) <= MAX_VERTICES;
	assign ca = AW'(q_cmd.a - kcq_pkg::VW'(1));
	assign cb = AW'(q_cmd.b - kcq_pkg::VW'(1));
	assign vi = AW'(v_q - VXW'(1));
	assign li = SW'(lvl_q - LW'(1));
	assign take = q_valid && q_ready;
	assign self_loop = (ea_q == eb_q);
	// Candidate mask at the current level: AND of rows of all earlier picks.
	assign cand_cur = (lvl_q == LW'(1)) ? {MAX_VERTICES{1'b1}} : cand_q[li];
	assign row_eff = row_vld_q ? row_rd_q : '0;
	assign deg_eff = deg_vld_q ? deg_rd_q : '0;
	assign deg_inc1 = (deg_eff != kcq_pkg::DEG_CAP) ? deg_eff + kcq_pkg::VW'(1)
		: kcq_pkg::DEG_CAP;
	assign deg_inc2 = (deg_eff >= kcq_pkg::DEG_CAP - kcq_pkg::VW'(1)) ? kcq_pkg::DEG_CAP
		: deg_eff + kcq_pkg::VW'(2);
	assign v_in_range = (v_q + (kx_q - VXW'(lvl_q))) <= nx_q;
	assign v_pass = ({1'b0, deg_eff} + 8'd1 >= {3'b0, kx_q[kcq_pkg::KW-1:0]})
		&& cand_cur[vi];

	assign q_ready = (state_q == kcq_pkg::ST_IDLE) && !resv_q;
	assign out_valid = resv_q;
	assign out_found = res_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			kcq_pkg::ST_IDLE: begin
				if (take) begin
					if (q_cmd.kind == kcq_pkg::KIND_EDGE) begin
						if (edge_ok) state_d = kcq_pkg::ST_EDGE1;
					end else if (k_cfg == '0 || int'(k_cfg) > MAX_CLIQUE
						|| {2'b0, k_cfg} > n_eff) begin
						state_d = kcq_pkg::ST_DONE;
					end else begin
						state_d = kcq_pkg::ST_CHECK;
					end
				end
			end
			kcq_pkg::ST_EDGE1: state_d = kcq_pkg::ST_EDGE2;
			kcq_pkg::ST_EDGE2: state_d = kcq_pkg::ST_IDLE;
			kcq_pkg::ST_CHECK: begin
				if (!v_in_range) state_d = kcq_pkg::ST_BACK;
				else if (v_pass) begin
					if (VXW'(lvl_q) == kx_q) state_d = kcq_pkg::ST_DONE;
					else state_d = kcq_pkg::ST_WAITRD;
				end
			end
			kcq_pkg::ST_WAITRD: state_d = kcq_pkg::ST_CHECK;
			kcq_pkg::ST_BACK: begin
				if (lvl_q == LW'(1)) state_d = kcq_pkg::ST_DONE;
				else state_d = kcq_pkg::ST_CHECK;
			end
			kcq_pkg::ST_DONE: state_d = kcq_pkg::ST_IDLE;
			default: state_d = kcq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		v_d = v_q;
		case (state_q)
			kcq_pkg::ST_IDLE: v_d = VXW'(1);
			kcq_pkg::ST_CHECK: begin
				if (v_in_range && !v_pass) v_d = v_q + VXW'(1);
			end
			kcq_pkg::ST_WAITRD: v_d = v_q + VXW'(1);
			kcq_pkg::ST_BACK: begin
				if (lvl_q != LW'(1))
					v_d = VXW'(stack_q[SW'(lvl_q - LW'(2))]) + VXW'(2);
			end
			default: begin
			end
		endcase
	end

	// Degree read address: the edge endpoints in turn, else the vertex tested next, fetched ahead from v_d.
	always_comb begin
		if (state_q == kcq_pkg::ST_IDLE && q_cmd.kind == kcq_pkg::KIND_EDGE)
			deg_addr = ca;
		else if (state_q == kcq_pkg::ST_EDGE1)
			deg_addr = eb_q;
		else
			deg_addr = AW'(v_d - VXW'(1));
	end

	always_ff @(posedge clk) begin
		deg_rd_q <= deg_mem[deg_addr];
		deg_vld_q <= adj_valid_q[deg_addr];
		case (state_q)
			kcq_pkg::ST_IDLE: begin
				ea_q <= ca;
				eb_q <= cb;
				kx_q <= VXW'(k_cfg);
				nx_q <= VXW'(n_eff);
				row_rd_q <= adj_mem[ca];
				row_vld_q <= adj_valid_q[ca];
			end
			kcq_pkg::ST_EDGE1: begin
				row_rd_q <= adj_mem[eb_q];
				row_vld_q <= adj_valid_q[eb_q];
				adj_mem[ea_q] <= row_eff | (MAX_VERTICES'(1) << eb_q);
				deg_mem[ea_q] <= self_loop ? deg_inc2 : deg_inc1;
			end
			kcq_pkg::ST_EDGE2: begin
				if (!self_loop) begin
					adj_mem[eb_q] <= row_eff | (MAX_VERTICES'(1) << ea_q);
					deg_mem[eb_q] <= deg_inc1;
				end
			end
			kcq_pkg::ST_CHECK: begin
				row_rd_q <= adj_mem[vi];
				row_vld_q <= adj_valid_q[vi];
				if (v_in_range && v_pass) stack_q[li] <= vi;
			end
			kcq_pkg::ST_WAITRD: begin
				cand_q[SW'(lvl_q)] <= cand_cur & row_eff;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kcq_pkg::ST_IDLE;
			adj_valid_q <= '0;
			v_q <= '0;
			lvl_q <= '0;
			ok_q <= 1'b0;
			res_q <= 1'b0;
			resv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_q <= v_d;
			if (resv_q && out_ready) resv_q <= 1'b0;
			case (state_q)
				kcq_pkg::ST_IDLE: begin
					lvl_q <= LW'(1);
					ok_q <= (k_cfg == '0);
				end
				kcq_pkg::ST_EDGE1: begin
					adj_valid_q[ea_q] <= 1'b1;
				end
				kcq_pkg::ST_EDGE2: begin
					adj_valid_q[eb_q] <= 1'b1;
				end
				kcq_pkg::ST_CHECK: begin
					if (v_in_range && v_pass && VXW'(lvl_q) == kx_q) ok_q <= 1'b1;
				end
				kcq_pkg::ST_WAITRD: begin
					lvl_q <= lvl_q + LW'(1);
				end
				kcq_pkg::ST_BACK: begin
					if (lvl_q != LW'(1)) lvl_q <= lvl_q - LW'(1);
				end
				kcq_pkg::ST_DONE: begin
					res_q <= ok_q;
					resv_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	`ASSERT_NEXT(a_done_result, clk, arst_n, state_q == kcq_pkg::ST_DONE, resv_q)
	`ASSERT_IMPLIES(a_lvl_range, clk, arst_n,
		state_q == kcq_pkg::ST_CHECK, lvl_q >= LW'(1) && VXW'(lvl_q) <= kx_q)
	`ASSERT_IMPLIES(a_no_take_busy, clk, arst_n, q_ready, state_q == kcq_pkg::ST_IDLE)
endmodule
`default_nettype wire

// ===== verif/k_clique_existence_search_checker.sv =====
// ----------------------------------------------------------------------------
// k_clique_existence_search_checker
// Watches the word, result and register channels of the clique search block,
// keeps its own copy of the graph and the settings, predicts the found flag
// of every search word and compares each result word against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module k_clique_existence_search_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         kind,
	input  logic [kcq_pkg::VW-1:0]       vertex_a,
	input  logic [kcq_pkg::VW-1:0]       vertex_b,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         found,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [kcq_pkg::CFG_W-1:0]    cfg_data,
	output int                           fail_count,
	output int                           waiting_count
);
	import kcq_pkg::*;

	localparam int NV = MAX_VERTICES_DEF;
	localparam int NK = MAX_CLIQUE_DEF;

	logic [NV:0] adj [0:NV];
	logic [VW-1:0] deg [0:NV];
	logic [KW-1:0] k_size;
	logic [VW-1:0] v_count;
	logic found_q [$];

	assign waiting_count = found_q.size();

	// Iterative depth-first search over increasing vertex numbers.
	function automatic logic clique_exists(int k, int n);
		int pick [0:NK];
		int lvl;
		int v;
		logic ok;
		if (n > NV) n = NV;
		if (k == 0) return 1'b1;
		if (k > NK || k > n) return 1'b0;
		lvl = 1;
		v = 1;
		while (1) begin
			if (v + (k - lvl) <= n) begin
				ok = (int'(deg[v]) + 1 >= k);
				for (int p = 1; p < lvl; p++)
					if (!adj[pick[p]][v]) ok = 1'b0;
				if (ok) begin
					pick[lvl] = v;
					if (lvl == k) return 1'b1;
					lvl++;
				end
				v++;
			end else begin
				if (lvl == 1) return 1'b0;
				lvl--;
				v = pick[lvl] + 1;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NV; i++) begin
				adj[i] <= '0;
				deg[i] <= '0;
			end
			k_size <= 5'd3;
			v_count <= 7'd64;
			fail_count <= 0;
			found_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_CLIQUE_SIZE) k_size <= cfg_data[KW-1:0];
				else v_count <= cfg_data[VW-1:0];
			end
			if (in_valid && in_ready) begin
				if (kind == KIND_EDGE) begin
					if (vertex_a >= 1 && vertex_a <= NV && vertex_b >= 1 && vertex_b <= NV) begin
						adj[vertex_a][vertex_b] <= 1'b1;
						adj[vertex_b][vertex_a] <= 1'b1;
						if (vertex_a == vertex_b) begin
							deg[vertex_a] <= (deg[vertex_a] >= DEG_CAP - 1) ? DEG_CAP
								: deg[vertex_a] + 7'd2;
						end else begin
							if (deg[vertex_a] < DEG_CAP) deg[vertex_a] <= deg[vertex_a] + 7'd1;
							if (deg[vertex_b] < DEG_CAP) deg[vertex_b] <= deg[vertex_b] + 7'd1;
						end
					end
				end else begin
					found_q.push_back(clique_exists(int'(k_size), int'(v_count)));
				end
			end
			if (out_valid && out_ready) begin
				if (found_q.size() == 0) begin
					$display("%0t: unexpected result word, found %0d", $time, found);
					fail_count <= fail_count + 1;
				end else begin
					if (found !== found_q[0]) begin
						$display("%0t: found mismatch, expected %0d actual %0d",
							$time, found_q[0], found);
						fail_count <= fail_count + 1;
					end
					void'(found_q.pop_front());
				end
			end
		end
	end
endmodule

// ===== verif/k_clique_existence_search_top_tb.sv =====
// ----------------------------------------------------------------------------
// k_clique_existence_search_top_tb
// Drives edge and search words with random gaps and result back-pressure
// through a sequence of clique size and vertex count settings, and reports
// the verdict from the checker's failure and waiting counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module k_clique_existence_search_top_tb;
	import kcq_pkg::*;

	localparam int IDLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = KIND_EDGE;
	logic [VW-1:0] vertex_a = '0;
	logic [VW-1:0] vertex_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_CLIQUE_SIZE;
	logic [CFG_W-1:0] cfg_data = '0;
	int fail_count;
	int waiting_count;
	int idle_cycles = 0;
	logic no_gaps = 1'b0;
	logic hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	k_clique_existence_search_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .vertex_a(vertex_a), .vertex_b(vertex_b),
		.out_valid(out_valid), .out_ready(out_ready), .found(found),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	k_clique_existence_search_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .vertex_a(vertex_a), .vertex_b(vertex_b),
		.out_valid(out_valid), .out_ready(out_ready), .found(found),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .waiting_count(waiting_count)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (no_gaps || r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(logic k, logic [VW-1:0] a, logic [VW-1:0] b);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		vertex_a <= a;
		vertex_b <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_edge(int a, int b);
		send_word(KIND_EDGE, VW'(a), VW'(b));
	endtask

	task automatic send_search();
		send_word(KIND_SEARCH, VW'($urandom), VW'($urandom));
	endtask

	// Waits for every result, lets the engine finish trailing edges, then writes.
	task automatic set_regs(int k, int n);
		in_valid <= 1'b0;
		while (waiting_count != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CLIQUE_SIZE;
		cfg_data <= CFG_W'(k);
		@(negedge clk);
		cfg_index <= CFG_VERTEX_COUNT;
		cfg_data <= CFG_W'(n);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_edge();
		int r;
		r = $urandom_range(0, 99);
		if (r < 78) send_edge($urandom_range(1, 10), $urandom_range(1, 10));
		else if (r < 86) send_edge($urandom_range(1, 64), $urandom_range(1, 64));
		else send_edge($urandom_range(0, 127), $urandom_range(0, 127));
	endtask

	always @(negedge clk) begin
		int stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			repeat (400) @(negedge clk);
			hold_req <= 1'b0;
			out_ready <= 1'b1;
		end else if (stall > 0) begin
			out_ready <= 1'b0;
			stall--;
		end else begin
			out_ready <= 1'b1;
			if (!no_gaps && $urandom_range(0, 9) < 3)
				stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
					: $urandom_range(10, 50);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int k;
		int n;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: reset settings on an empty graph, then a triangle.
		send_search();
		send_edge(1, 2);
		send_edge(2, 3);
		send_edge(3, 1);
		send_search();
		send_edge(0, 5);
		send_edge(65, 3);
		send_edge(127, 127);
		send_edge(5, 0);
		send_edge(4, 4);
		send_edge(64, 63);
		send_edge(1, 2);
		send_search();
		set_regs(0, 5);
		send_search();
		set_regs(16, 64);
		send_search();
		set_regs(17, 64);
		send_search();
		set_regs(31, 127);
		send_search();
		set_regs(1, 1);
		send_search();
		set_regs(4, 3);
		send_search();
		set_regs(2, 0);
		send_search();
		set_regs(2, 127);
		send_search();

		for (int ph = 0; ph < 30; ph++) begin
			n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(0, 127);
			if (n > 12) k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
				: $urandom_range(17, 31);
			else k = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom_range(0, 31);
			if (ph == 29) begin
				k = 3;
				n = 64;
			end
			set_regs(k, n);
			no_gaps <= (ph % 7 == 3);
			if (ph == 4) hold_req <= 1'b1;
			for (int i = 0; i < 60; i++) begin
				if ($urandom_range(0, 3) == 0) send_search();
				else random_edge();
			end
		end

		in_valid <= 1'b0;
		no_gaps <= 1'b0;
		while (waiting_count != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0 && waiting_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

// ===== k_clique_existence_search_top.f =====
+incdir+hw/rtl
hw/rtl/kcq_pkg.sv
hw/rtl/kcq_front.sv
hw/rtl/kcq_engine.sv
hw/rtl/k_clique_existence_search_top.sv
verif/k_clique_existence_search_checker.sv
verif/k_clique_existence_search_top_tb.sv
